>>> design/tcgb_pkg.sv
package tcgb_pkg;

    // field widths of the stream words
    localparam int CH_W    = 8;
    localparam int STEPS_W = 11;
    localparam int KIND_W  = 2;
    localparam int DATA_W  = 24;

    // operation codes carried on the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_LEFT   = 2'd2,
        KIND_RIGHT  = 2'd3
    } kind_t;

    // one result word as built by the sequencer
    typedef struct packed {
        logic [STEPS_W-1:0] deleted_count;
        logic [CH_W-1:0]    ch_res;
        logic               has_char;
        logic               last;
    } res_t;

endpackage

>>> design/tcgb_ram.sv
module tcgb_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [tcgb_pkg::CH_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [tcgb_pkg::CH_W-1:0] rd_data
);

    logic [tcgb_pkg::CH_W-1:0] mem [DEPTH];
    logic [tcgb_pkg::CH_W-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its data while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/tcgb_seq.sv
module tcgb_seq #(
    parameter int DEPTH    = 1024,
    parameter int TAIL_LEN = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tcgb_pkg::KIND_W-1:0]  in_kind,
    input  logic [tcgb_pkg::CH_W-1:0]    in_ch,
    input  logic [tcgb_pkg::STEPS_W-1:0] in_steps,
    input  logic                         out_free,
    output logic                         res_load,
    output tcgb_pkg::res_t               res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = $clog2(TAIL_LEN + 1);
    localparam int SW = tcgb_pkg::STEPS_W;
    localparam int MW = (CW > SW) ? CW : SW;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DEL    = 6'b000010,
        ST_MOVE   = 6'b000100,
        ST_TSTART = 6'b001000,
        ST_TRD    = 6'b010000,
        ST_TLD    = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] lc_reg, lc_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic [SW-1:0] done_reg, done_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic          dir_right_reg, dir_right_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [TW-1:0] rem_reg, rem_next;

    logic                      lwe, lre, rwe, rre;
    logic [AW-1:0]             lwa, lra, rwa, rra;
    logic [tcgb_pkg::CH_W-1:0] lwd, rwd, l_rdata, r_rdata;

    logic [CW-1:0] lc_dec, rc_dec, src_cnt, tail_start;
    logic [CW:0]   total;
    logic [MW-1:0] lc_w, steps_w, del_n, tail_n;
    logic          go;

    // left and right stacks
    tcgb_ram #(.DEPTH(DEPTH), .AW(AW)) u_left (
        .clk     (clk),
        .wr_en   (lwe),
        .wr_addr (lwa),
        .wr_data (lwd),
        .rd_en   (lre),
        .rd_addr (lra),
        .rd_data (l_rdata)
    );

    tcgb_ram #(.DEPTH(DEPTH), .AW(AW)) u_right (
        .clk     (clk),
        .wr_en   (rwe),
        .wr_addr (rwa),
        .wr_data (rwd),
        .rd_en   (rre),
        .rd_addr (rra),
        .rd_data (r_rdata)
    );

    // shared count arithmetic
    assign lc_dec     = lc_reg - CW'(1);
    assign rc_dec     = rc_reg - CW'(1);
    assign total      = {1'b0, lc_reg} + {1'b0, rc_reg};
    assign src_cnt    = dir_right_reg ? rc_reg : lc_reg;
    assign go         = (done_reg < steps_reg) && (src_cnt != '0);
    assign lc_w       = MW'(lc_reg);
    assign steps_w    = MW'(in_steps);
    assign del_n      = (steps_w < lc_w) ? steps_w : lc_w;
    assign tail_n     = (lc_w < MW'(TAIL_LEN)) ? lc_w : MW'(TAIL_LEN);
    assign tail_start = lc_reg - tail_n[CW-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        lc_next        = lc_reg;
        rc_next        = rc_reg;
        done_next      = done_reg;
        steps_next     = steps_reg;
        dir_right_next = dir_right_reg;
        pend_next      = 1'b0;
        wa_next        = wa_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        in_ready       = (state_reg == ST_IDLE);
        res_load       = 1'b0;
        res            = '0;
        lwe            = 1'b0;
        lwa            = '0;
        lwd            = '0;
        lre            = 1'b0;
        lra            = '0;
        rwe            = 1'b0;
        rwa            = '0;
        rwd            = '0;
        rre            = 1'b0;
        rra            = '0;

        // finish the transfer issued last cycle
        if (pend_reg)
        begin
            if (dir_right_reg)
            begin
                lwe = 1'b1;
                lwa = wa_reg;
                lwd = r_rdata;
            end
            else
            begin
                rwe = 1'b1;
                rwa = wa_reg;
                rwd = l_rdata;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (tcgb_pkg::kind_t'(in_kind))
                        tcgb_pkg::KIND_INSERT:
                        begin
                            if (total != (CW+1)'(DEPTH))
                            begin
                                lwe     = 1'b1;
                                lwa     = lc_reg[AW-1:0];
                                lwd     = in_ch;
                                lc_next = lc_reg + CW'(1);
                            end
                        end
                        tcgb_pkg::KIND_DELETE:
                        begin
                            done_next  = del_n[SW-1:0];
                            lc_next    = lc_reg - del_n[CW-1:0];
                            state_next = ST_DEL;
                        end
                        tcgb_pkg::KIND_LEFT, tcgb_pkg::KIND_RIGHT:
                        begin
                            done_next      = '0;
                            steps_next     = in_steps;
                            dir_right_next = (tcgb_pkg::kind_t'(in_kind) == tcgb_pkg::KIND_RIGHT);
                            state_next     = ST_MOVE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_DEL:
            begin
                if (out_free)
                begin
                    res_load          = 1'b1;
                    res.deleted_count = done_reg;
                    res.last          = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            // one character across the cursor per cycle
            ST_MOVE:
            begin
                if (go)
                begin
                    done_next = done_reg + SW'(1);
                    pend_next = 1'b1;
                    if (dir_right_reg)
                    begin
                        rre     = 1'b1;
                        rra     = rc_dec[AW-1:0];
                        rc_next = rc_dec;
                        wa_next = lc_reg[AW-1:0];
                        lc_next = lc_reg + CW'(1);
                    end
                    else
                    begin
                        lre     = 1'b1;
                        lra     = lc_dec[AW-1:0];
                        lc_next = lc_dec;
                        wa_next = rc_reg[AW-1:0];
                        rc_next = rc_reg + CW'(1);
                    end
                end
                else
                begin
                    state_next = ST_TSTART;
                end
            end

            // set up the tail readout, or report an empty tail
            ST_TSTART:
            begin
                if (lc_reg == '0)
                begin
                    if (out_free)
                    begin
                        res_load   = 1'b1;
                        res.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ptr_next   = tail_start[AW-1:0];
                    rem_next   = tail_n[TW-1:0];
                    state_next = ST_TRD;
                end
            end

            ST_TRD:
            begin
                lre        = 1'b1;
                lra        = ptr_reg;
                state_next = ST_TLD;
            end

            ST_TLD:
            begin
                if (out_free)
                begin
                    res_load     = 1'b1;
                    res.ch_res   = l_rdata;
                    res.has_char = 1'b1;
                    res.last     = (rem_reg == TW'(1));
                    ptr_next     = ptr_reg + AW'(1);
                    rem_next     = rem_reg - TW'(1);
                    state_next   = (rem_reg == TW'(1)) ? ST_IDLE : ST_TRD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lc_reg    <= '0;
            rc_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            rc_reg    <= rc_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        done_reg      <= done_next;
        steps_reg     <= steps_next;
        dir_right_reg <= dir_right_next;
        wa_reg        <= wa_next;
        ptr_reg       <= ptr_next;
        rem_reg       <= rem_next;
    end

endmodule

>>> design/text_cursor_gap_buffer.sv
// channel   | signals                          | contents
// ----------+----------------------------------+-------------------------------------------
// s_axis    | tvalid tready tdata tuser        | tuser kind, tdata ch and steps
// m_axis    | tvalid tready tdata tuser tlast  | tuser has_char, tdata deleted_count, ch_res
//
// insert is taken in the idle state; delete goes through ST_DEL and waits out any output stall
// a cursor move transfers the characters actually moved, then reads out min(left count, TAIL_LEN)
// tail chars; each stack has one read port, so the transfer goes one char a cycle and a tail char
// passes through a read state and then a load state, which waits on the output
// reset clears the state, the counts, the pending transfer and the output valid; the stacks hold whatever they held
// a stalled m_axis holds the sequencer in any state that loads a result word; s_axis is ready only when idle
module text_cursor_gap_buffer #(
    parameter int DEPTH    = 1024,
    parameter int TAIL_LEN = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tcgb_pkg::DATA_W-1:0] s_axis_tdata,   // ch[7:0], steps[18:8], zero pad
    input  logic [tcgb_pkg::KIND_W-1:0] s_axis_tuser,   // kind[1:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [tcgb_pkg::DATA_W-1:0] m_axis_tdata,   // deleted_count[10:0], ch_res[18:11], pad
    output logic [0:0]                  m_axis_tuser,   // has_char[0]
    output logic                        m_axis_tlast
);

    localparam int PAD_W = tcgb_pkg::DATA_W - tcgb_pkg::STEPS_W - tcgb_pkg::CH_W;

    logic           m_valid_reg;
    tcgb_pkg::res_t m_res_reg;
    logic           out_free;
    logic           res_load;
    tcgb_pkg::res_t res;

    assign out_free = !m_valid_reg || m_axis_tready;

    tcgb_seq #(.DEPTH(DEPTH), .TAIL_LEN(TAIL_LEN)) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_kind  (s_axis_tuser),
        .in_ch    (s_axis_tdata[tcgb_pkg::CH_W-1:0]),
        .in_steps (s_axis_tdata[tcgb_pkg::CH_W +: tcgb_pkg::STEPS_W]),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_res_reg.ch_res, m_res_reg.deleted_count};
    assign m_axis_tuser  = m_res_reg.has_char;
    assign m_axis_tlast  = m_res_reg.last;

`ifndef SYNTHESIS
    // an empty or delete word carries no character
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[18:11] == '0))
        else $error("character on a word without has_char");

    // a tail character word never reports a delete count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[10:0] == '0))
        else $error("delete count on a tail character word");

    // a delete or move keeps the input closed on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready &&
            (s_axis_tuser == tcgb_pkg::KIND_DELETE || s_axis_tuser == tcgb_pkg::KIND_LEFT ||
             s_axis_tuser == tcgb_pkg::KIND_RIGHT)) |=> !s_axis_tready)
        else $error("input accepted while an operation is in progress");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH        = 1024;
    localparam int TAIL_LEN     = 10;
    localparam int MAX_STEPS    = 1024;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_WORDS = 244;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [tcgb_pkg::DATA_W-1:0]   s_axis_tdata = '0;   // ch[7:0], steps[18:8], zero pad
    logic [tcgb_pkg::KIND_W-1:0]   s_axis_tuser = '0;   // kind[1:0]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [tcgb_pkg::DATA_W-1:0]   m_axis_tdata;        // deleted_count[10:0], ch_res[18:11], pad
    logic [0:0]                    m_axis_tuser;        // has_char[0]
    logic                          m_axis_tlast;

    // shadow copy of the edit buffer
    logic [tcgb_pkg::CH_W-1:0] left_chars  [DEPTH];
    logic [tcgb_pkg::CH_W-1:0] right_chars [DEPTH];
    int                        left_len  = 0;
    int                        right_len = 0;

    tcgb_pkg::res_t pending_results [$];

    int errors        = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    text_cursor_gap_buffer #(
        .DEPTH    (DEPTH),
        .TAIL_LEN (TAIL_LEN)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    // add one word to the end of the expected queue
    task automatic expect_word(input tcgb_pkg::res_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // queue up to TAIL_LEN characters left of the cursor, oldest first, or one empty word
    task automatic push_tail();
        int             n;
        tcgb_pkg::res_t r;
        n = (left_len < TAIL_LEN) ? left_len : TAIL_LEN;
        if (n == 0)
        begin
            r = '{deleted_count: '0, ch_res: '0, has_char: 1'b0, last: 1'b1};
            expect_word(r);
        end
        for (int i = 0; i < n; i++)
        begin
            r.deleted_count = '0;
            r.ch_res        = left_chars[left_len - n + i];
            r.has_char      = 1'b1;
            r.last          = (i == n - 1);
            expect_word(r);
        end
    endtask

    // apply one edit word to the shadow buffer and queue its result words
    task automatic apply_edit(input tcgb_pkg::kind_t k, input logic [tcgb_pkg::CH_W-1:0] c,
                              input logic [tcgb_pkg::STEPS_W-1:0] n);
        int             moved;
        tcgb_pkg::res_t r;
        moved = 0;
        case (k)
            tcgb_pkg::KIND_INSERT:
            begin
                if (left_len + right_len < DEPTH)
                begin
                    left_chars[left_len] = c;
                    left_len++;
                end
            end
            tcgb_pkg::KIND_DELETE:
            begin
                moved = (int'(n) < left_len) ? int'(n) : left_len;
                left_len -= moved;
                r = '{deleted_count: moved[tcgb_pkg::STEPS_W-1:0], ch_res: '0,
                      has_char: 1'b0, last: 1'b1};
                expect_word(r);
            end
            tcgb_pkg::KIND_LEFT:
            begin
                while (moved < int'(n) && left_len > 0 && right_len < DEPTH)
                begin
                    left_len--;
                    right_chars[right_len] = left_chars[left_len];
                    right_len++;
                    moved++;
                end
                push_tail();
            end
            default:
            begin
                while (moved < int'(n) && right_len > 0 && left_len < DEPTH)
                begin
                    right_len--;
                    left_chars[left_len] = right_chars[right_len];
                    left_len++;
                    moved++;
                end
                push_tail();
            end
        endcase
    endtask

    // offer one edit word and wait until it is taken
    task automatic send_word(input tcgb_pkg::kind_t k, input logic [tcgb_pkg::CH_W-1:0] c,
                             input logic [tcgb_pkg::STEPS_W-1:0] n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(tcgb_pkg::DATA_W - tcgb_pkg::STEPS_W - tcgb_pkg::CH_W){1'b0}}, n, c};
        s_axis_tuser  <= k;
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_edit(k, c, n);
        words_sent++;
    endtask

    // wait until every expected word is back, then let the block settle
    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // change idling between phases, away from the rising edge
    task automatic set_idling(input int send_pct, input int recv_pct, input int hold);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        hold_left     = hold;
        @(posedge clk);
    endtask

    // output ready: long hold-off first, then random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_field(input string name, input logic [tcgb_pkg::STEPS_W-1:0] want,
                                input logic [tcgb_pkg::STEPS_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // compare each returned word with the oldest expectation
    always @(posedge clk)
    begin
        tcgb_pkg::res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected word, expected none, actual tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("deleted_count", want.deleted_count, m_axis_tdata[10:0]);
                report_field("ch_res", tcgb_pkg::STEPS_W'(want.ch_res),
                             tcgb_pkg::STEPS_W'(m_axis_tdata[18:11]));
                report_field("has_char", tcgb_pkg::STEPS_W'(want.has_char),
                             tcgb_pkg::STEPS_W'(m_axis_tuser[0]));
                report_field("last", tcgb_pkg::STEPS_W'(want.last),
                             tcgb_pkg::STEPS_W'(m_axis_tlast));
                words_checked++;
            end
        end
    end

    function automatic logic [tcgb_pkg::STEPS_W-1:0] pick_steps();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return tcgb_pkg::STEPS_W'($urandom_range(12));
        else if (r < 92)
            return tcgb_pkg::STEPS_W'($urandom_range(40));
        else if (r < 97)
            return tcgb_pkg::STEPS_W'($urandom_range(MAX_STEPS));
        else
            return tcgb_pkg::STEPS_W'(MAX_STEPS);
    endfunction

    // empty buffer cases, extreme characters, zero and oversized counts
    task automatic test_directed();
        logic [tcgb_pkg::CH_W-1:0] chars [12];
        chars = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                  8'h7F, 8'hFE, 8'h41, 8'h42, 8'h43, 8'h0A};
        set_idling(0, 0, 0);
        send_word(tcgb_pkg::KIND_LEFT, 8'h00, 11'd0);
        send_word(tcgb_pkg::KIND_DELETE, 8'hFF, 11'd5);
        send_word(tcgb_pkg::KIND_RIGHT, 8'h00, 11'd1024);
        foreach (chars[i])
            send_word(tcgb_pkg::KIND_INSERT, chars[i], 11'(i * 170));
        send_word(tcgb_pkg::KIND_LEFT, 8'h00, 11'd3);
        send_word(tcgb_pkg::KIND_LEFT, 8'h00, 11'd0);
        send_word(tcgb_pkg::KIND_RIGHT, 8'h00, 11'd1);
        send_word(tcgb_pkg::KIND_DELETE, 8'h00, 11'd0);
        send_word(tcgb_pkg::KIND_DELETE, 8'h00, 11'd2);
        send_word(tcgb_pkg::KIND_RIGHT, 8'h00, 11'd1024);
        send_word(tcgb_pkg::KIND_LEFT, 8'h00, 11'd1024);
        send_word(tcgb_pkg::KIND_RIGHT, 8'h00, 11'd5);
        send_word(tcgb_pkg::KIND_DELETE, 8'hFF, 11'd1024);
        drain(DRAIN_CYCLES);
    endtask

    // type a line, then sweep every character across the cursor with oversized counts
    task automatic test_long_moves();
        set_idling(11, 11, 0);
        for (int i = 0; i < 20; i++)
            send_word(tcgb_pkg::KIND_INSERT, tcgb_pkg::CH_W'($urandom_range(255)), '0);
        send_word(tcgb_pkg::KIND_LEFT, 8'h00, 11'd1024);
        send_word(tcgb_pkg::KIND_DELETE, 8'h00, 11'd1);
        send_word(tcgb_pkg::KIND_RIGHT, 8'h00, 11'd1024);
        send_word(tcgb_pkg::KIND_LEFT, 8'h00, 11'd7);
        send_word(tcgb_pkg::KIND_DELETE, 8'h00, 11'd1024);
        drain(DRAIN_CYCLES);
    endtask

    // output held off for a long stretch while edits are offered
    task automatic test_backpressure();
        set_idling(0, 0, 400);
        for (int i = 0; i < 16; i++)
            send_word(tcgb_pkg::kind_t'($urandom_range(3)),
                      tcgb_pkg::CH_W'($urandom_range(255)),
                      tcgb_pkg::STEPS_W'($urandom_range(6)));
        drain(DRAIN_CYCLES);
    endtask

    // typing bursts mixed with cursor moves and deletes, per idling phase
    task automatic test_random();
        int phase_pct [4][2];
        int budget;
        int burst;
        int r;
        phase_pct = '{'{0, 0}, '{51, 0}, '{0, 51}, '{11, 11}};
        for (int p = 0; p < 4; p++)
        begin
            set_idling(phase_pct[p][0], phase_pct[p][1], 0);
            budget = RANDOM_WORDS / 4;
            while (budget > 0)
            begin
                r = $urandom_range(99);
                if (r < 45)
                begin
                    burst = $urandom_range(1, 8);
                    for (int i = 0; i < burst && budget > 0; i++)
                    begin
                        send_word(tcgb_pkg::KIND_INSERT, tcgb_pkg::CH_W'($urandom_range(255)),
                                  tcgb_pkg::STEPS_W'($urandom_range(2047)));
                        budget--;
                    end
                end
                else
                begin
                    if (r < 62)
                        send_word(tcgb_pkg::KIND_DELETE, tcgb_pkg::CH_W'($urandom_range(255)),
                                  pick_steps());
                    else if (r < 81)
                        send_word(tcgb_pkg::KIND_LEFT, tcgb_pkg::CH_W'($urandom_range(255)),
                                  pick_steps());
                    else
                        send_word(tcgb_pkg::KIND_RIGHT, tcgb_pkg::CH_W'($urandom_range(255)),
                                  pick_steps());
                    budget--;
                end
            end
            drain(DRAIN_CYCLES);
        end
    endtask

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_moves();
        test_backpressure();
        test_random();
        drain(DRAIN_CYCLES * 2);
        $display("covered %0d edit words and %0d result words in %0d cycles",
                 words_sent, words_checked, cycle_count);
        $display("empty buffer, oversized counts, long sweeps, long output stall, four idling mixes");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
